>>> hw/rtl/point_segment_distance_defines.svh
// Assertion macros shared by the point-to-segment distance RTL.
// No dependencies; included by the files that carry assertions.
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/psd_pkg.sv
// Shared constants and the front-to-back item type for point_segment_distance.
// No dependencies.
package psd_pkg;

   localparam int COORD_W   = 32;              // coordinate width
   localparam int FRAC_BITS = 16;              // fraction bits of r
   localparam int OUT_W     = 32;              // distance / projection width
   localparam int DIFF_W    = COORD_W + 1;     // coordinate differences
   localparam int SP_W      = 2 * DIFF_W;      // signed product
   localparam int SUM_W     = 2 * COORD_W + 2; // magnitude of a sum of two products
   localparam int SS_W      = SUM_W + 1;       // signed sum of two products
   localparam int HALF_W    = SUM_W / 2;       // limb for squaring
   localparam int SQ_W      = 2 * SUM_W;       // square of a sum magnitude
   localparam int Q_W       = SUM_W;           // distance quotient bits
   localparam int ROOT_W    = Q_W / 2;         // square root bits
   localparam int RM_W      = ROOT_W + 2;      // root remainder
   localparam int PQ_W      = OUT_W;           // projection quotient bits
   localparam int PNUM_W    = SUM_W + FRAC_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = QPTR_W + 1;

   localparam logic [OUT_W-1:0] PROJ_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] PROJ_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [OUT_W-1:0] DIST_MAX  = {OUT_W{1'b1}};

   typedef struct packed {
      logic             degenerate;
      logic             perp;        // foot of perpendicular on the segment
      logic             rn_neg;
      logic [SUM_W-1:0] rn_mag;
      logic [SUM_W-1:0] rd;
      logic [SUM_W-1:0] cr_mag;
      logic [SUM_W-1:0] m;           // smaller squared endpoint distance
   } psd_item_type;

endpackage

>>> hw/rtl/psd_front.sv
// Front part: registers items, forms differences, products and sums, classifies.
// Depends on psd_pkg.
module psd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                en,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_point_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_point_lat,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_start_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_start_lat,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_end_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]  req_end_lat,
   output logic                                push,
   output psd_pkg::psd_item_type               item
);

   localparam int CW = psd_pkg::COORD_W;
   localparam int DW = psd_pkg::DIFF_W;
   localparam int PW = psd_pkg::SP_W;
   localparam int SW = psd_pkg::SUM_W;
   localparam int XW = psd_pkg::SS_W;

   logic f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff, f5_valid_ff;
   logic f2_degen_ff, f3_degen_ff, f4_degen_ff;

   logic signed [CW-1:0] px_ff, py_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, ux_ff, uy_ff, vx_ff, vy_ff;
   logic signed [DW-1:0] dx_in, dy_in, ux_in, uy_in, vx_in, vy_in;
   logic signed [PW-1:0] p_rn1_ff, p_rn2_ff, p_rd1_ff, p_rd2_ff, p_c1_ff, p_c2_ff;
   logic signed [PW-1:0] p_a1_ff, p_a2_ff, p_b1_ff, p_b2_ff;
   logic signed [XW-1:0] rn_s_ff, cr_s_ff, rn_s_in, cr_s_in;
   logic [SW-1:0]        rd_ff, d1_ff, d2_ff, rd_in, d1_in, d2_in;
   psd_pkg::psd_item_type item_ff, item_in;

   assign dx_in = DW'(ex_ff) - DW'(sx_ff);
   assign dy_in = DW'(ey_ff) - DW'(sy_ff);
   assign ux_in = DW'(px_ff) - DW'(sx_ff);
   assign uy_in = DW'(py_ff) - DW'(sy_ff);
   assign vx_in = DW'(px_ff) - DW'(ex_ff);
   assign vy_in = DW'(py_ff) - DW'(ey_ff);

   assign rn_s_in = XW'(p_rn1_ff) + XW'(p_rn2_ff);
   assign cr_s_in = XW'(p_c1_ff) - XW'(p_c2_ff);
   assign rd_in   = SW'(unsigned'(p_rd1_ff)) + SW'(unsigned'(p_rd2_ff));
   assign d1_in   = SW'(unsigned'(p_a1_ff)) + SW'(unsigned'(p_a2_ff));
   assign d2_in   = SW'(unsigned'(p_b1_ff)) + SW'(unsigned'(p_b2_ff));

   always_comb begin
      item_in.degenerate = f4_degen_ff;
      item_in.rn_neg     = rn_s_ff[XW-1];
      item_in.rn_mag     = rn_s_ff[XW-1] ? SW'(-rn_s_ff) : SW'(rn_s_ff);
      item_in.perp       = !rn_s_ff[XW-1] && (rn_s_ff[SW-1:0] <= rd_ff);
      item_in.rd         = rd_ff;
      item_in.cr_mag     = cr_s_ff[XW-1] ? SW'(-cr_s_ff) : SW'(cr_s_ff);
      // on a tie the end point's value is taken; both are equal
      item_in.m          = (d1_ff < d2_ff) ? d1_ff : d2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
         f5_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= start;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
         f5_valid_ff <= f4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= req_point_lon;
         py_ff <= req_point_lat;
         sx_ff <= req_start_lon;
         sy_ff <= req_start_lat;
         ex_ff <= req_end_lon;
         ey_ff <= req_end_lat;

         dx_ff <= dx_in;
         dy_ff <= dy_in;
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         f2_degen_ff <= (dx_in == '0) && (dy_in == '0);

         p_rn1_ff <= PW'(ux_ff) * PW'(dx_ff);
         p_rn2_ff <= PW'(uy_ff) * PW'(dy_ff);
         p_rd1_ff <= PW'(dx_ff) * PW'(dx_ff);
         p_rd2_ff <= PW'(dy_ff) * PW'(dy_ff);
         p_c1_ff  <= PW'(ux_ff) * PW'(dy_ff);
         p_c2_ff  <= PW'(uy_ff) * PW'(dx_ff);
         p_a1_ff  <= PW'(ux_ff) * PW'(ux_ff);
         p_a2_ff  <= PW'(uy_ff) * PW'(uy_ff);
         p_b1_ff  <= PW'(vx_ff) * PW'(vx_ff);
         p_b2_ff  <= PW'(vy_ff) * PW'(vy_ff);
         f3_degen_ff <= f2_degen_ff;

         rn_s_ff <= rn_s_in;
         cr_s_ff <= cr_s_in;
         rd_ff   <= rd_in;
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         f4_degen_ff <= f3_degen_ff;

         item_ff <= item_in;
      end
   end

   assign push = f5_valid_ff;
   assign item = item_ff;

endmodule

>>> hw/rtl/psd_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on psd_pkg and point_segment_distance_defines.svh.
`include "point_segment_distance_defines.svh"

module psd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  psd_pkg::psd_item_type wr_item,
   output logic                  full,
   output logic                  pop,
   output psd_pkg::psd_item_type rd_item
);

   localparam int DEPTH = psd_pkg::QUEUE_DEPTH;
   localparam int PW    = psd_pkg::QPTR_W;
   localparam int CNTW  = psd_pkg::QCNT_W;

   psd_pkg::psd_item_type entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic            wr, empty;

   assign full  = (count_ff == CNTW'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr    = push && !full;
   assign pop   = !empty;          // the back part never stalls
   assign rd_item = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

   `PSD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNTW'(DEPTH), "queue count over depth")
   `PSD_ASSERT_NOW(a_ptr_match, clock, reset, 1'b1, (wr_ptr_ff - rd_ptr_ff) == count_ff[PW-1:0], "queue pointers disagree with count")
   `PSD_ASSERT_NEXT(a_count_up, clock, reset, wr && !pop, count_ff == $past(count_ff) + 1'b1, "queue count missed a write")

endmodule

>>> hw/rtl/psd_back.sv
// Back part: squares the cross product, divides, takes square roots, saturates.
// Depends on psd_pkg.
module psd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop,
   input  psd_pkg::psd_item_type        rd_item,
   output logic                         rsp_valid,
   output logic [psd_pkg::OUT_W-1:0]    rsp_distance,
   output logic signed [psd_pkg::OUT_W-1:0] rsp_projection,
   output logic                         rsp_degenerate
);

   localparam int SW  = psd_pkg::SUM_W;
   localparam int HW  = psd_pkg::HALF_W;
   localparam int QW  = psd_pkg::Q_W;
   localparam int QSW = psd_pkg::SQ_W;
   localparam int RW  = psd_pkg::ROOT_W;
   localparam int MW  = psd_pkg::RM_W;
   localparam int PQW = psd_pkg::PQ_W;
   localparam int PNW = psd_pkg::PNUM_W;
   localparam int OW  = psd_pkg::OUT_W;
   localparam int FB  = psd_pkg::FRAC_BITS;
   localparam int DSW = (RW > OW) ? RW : OW;

   typedef struct packed {
      logic           valid;
      logic           degenerate;
      logic           rn_neg;
      logic           povf;
      logic [SW-1:0]  drem;
      logic [QW-1:0]  dnum;
      logic [SW-1:0]  dden;
      logic [QW-1:0]  dquo;
      logic [SW-1:0]  prem;
      logic [PQW-1:0] pnum;
      logic [SW-1:0]  pden;
      logic [PQW-1:0] pquo;
   } psd_div_type;

   typedef struct packed {
      logic           valid;
      logic           degenerate;
      logic           rn_neg;
      logic           povf;
      logic           prem_nz;
      logic [PQW-1:0] pquo;
      logic [QW-1:0]  rad;
      logic [MW-1:0]  rem;
      logic [RW-1:0]  root;
   } psd_sqrt_type;

   // squaring stage
   logic                  s0_valid_ff;
   psd_pkg::psd_item_type s0_item_ff;
   logic [SW-1:0]         s0_hh_ff, s0_hl_ff, s0_ll_ff;

   logic [QSW-1:0] sq_v;
   logic [PNW-1:0] pnum_full;
   logic [SW-1:0]  dden0;

   psd_div_type  div_ff [QW+1];
   psd_div_type  div_in [QW+1];
   psd_sqrt_type rt_ff  [RW+1];
   psd_sqrt_type rt_in  [RW+1];

   logic                 out_valid_ff, out_degen_ff;
   logic [OW-1:0]        out_dist_ff, out_dist_in;
   logic [OW-1:0]        out_proj_ff, out_proj_in;
   logic [PQW:0]         ceil_v;
   logic [DSW-1:0]       root_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      s0_item_ff <= rd_item;
      s0_hh_ff   <= SW'(rd_item.cr_mag[SW-1:HW]) * SW'(rd_item.cr_mag[SW-1:HW]);
      s0_hl_ff   <= SW'(rd_item.cr_mag[SW-1:HW]) * SW'(rd_item.cr_mag[HW-1:0]);
      s0_ll_ff   <= SW'(rd_item.cr_mag[HW-1:0]) * SW'(rd_item.cr_mag[HW-1:0]);
   end

   // cross^2 from limbs; endpoint case divides m by one
   assign sq_v = (QSW'(s0_hh_ff) << (2 * HW)) + (QSW'(s0_hl_ff) << (HW + 1))
               + QSW'(s0_ll_ff);
   assign dden0 = (s0_item_ff.perp && !s0_item_ff.degenerate) ? s0_item_ff.rd : SW'(1);
   assign pnum_full = PNW'(s0_item_ff.rn_mag) << FB;

   always_comb begin
      logic [QSW-1:0] num;
      num = s0_item_ff.perp ? sq_v : QSW'(s0_item_ff.m);
      div_in[0].valid      = s0_valid_ff;
      div_in[0].degenerate = s0_item_ff.degenerate;
      div_in[0].rn_neg     = s0_item_ff.rn_neg;
      // quotient would not fit PQ_W bits: rn * 2^FB >= rd * 2^PQW
      div_in[0].povf       = PNW'(s0_item_ff.rn_mag) >= (PNW'(s0_item_ff.rd) << (PQW - FB));
      div_in[0].drem       = num[QSW-1:QW];
      div_in[0].dnum       = num[QW-1:0];
      div_in[0].dden       = dden0;
      div_in[0].dquo       = '0;
      div_in[0].prem       = SW'(pnum_full >> PQW);
      div_in[0].pnum       = pnum_full[PQW-1:0];
      div_in[0].pden       = s0_item_ff.degenerate ? SW'(1) : s0_item_ff.rd;
      div_in[0].pquo       = '0;
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [SW:0] dt, dsub, pt, psub;
      logic        dge, pge;

      assign dt   = {div_ff[k].drem, div_ff[k].dnum[QW-1]};
      assign dsub = dt - {1'b0, div_ff[k].dden};
      assign dge  = dt >= {1'b0, div_ff[k].dden};
      assign pt   = {div_ff[k].prem, div_ff[k].pnum[PQW-1]};
      assign psub = pt - {1'b0, div_ff[k].pden};
      assign pge  = pt >= {1'b0, div_ff[k].pden};

      always_comb begin
         div_in[k+1]      = div_ff[k];
         div_in[k+1].drem = dge ? dsub[SW-1:0] : dt[SW-1:0];
         div_in[k+1].dnum = div_ff[k].dnum << 1;
         div_in[k+1].dquo = {div_ff[k].dquo[QW-2:0], dge};
         if (k < PQW) begin
            div_in[k+1].prem = pge ? psub[SW-1:0] : pt[SW-1:0];
            div_in[k+1].pnum = div_ff[k].pnum << 1;
            div_in[k+1].pquo = {div_ff[k].pquo[PQW-2:0], pge};
         end
      end
   end

   always_comb begin
      rt_in[0].valid      = div_ff[QW].valid;
      rt_in[0].degenerate = div_ff[QW].degenerate;
      rt_in[0].rn_neg     = div_ff[QW].rn_neg;
      rt_in[0].povf       = div_ff[QW].povf;
      rt_in[0].prem_nz    = (div_ff[QW].prem != '0);
      rt_in[0].pquo       = div_ff[QW].pquo;
      rt_in[0].rad        = div_ff[QW].dquo;
      rt_in[0].rem        = '0;
      rt_in[0].root       = '0;
   end

   // digit-by-digit square root, one root bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_root
      logic [MW+1:0] r2, trial, rsub;
      logic          rge;

      assign r2    = {rt_ff[k].rem, rt_ff[k].rad[QW-1:QW-2]};
      assign trial = (MW+2)'({rt_ff[k].root, 2'b01});
      assign rsub  = r2 - trial;
      assign rge   = r2 >= trial;

      always_comb begin
         rt_in[k+1]      = rt_ff[k];
         rt_in[k+1].rad  = rt_ff[k].rad << 2;
         rt_in[k+1].rem  = rge ? rsub[MW-1:0] : r2[MW-1:0];
         rt_in[k+1].root = {rt_ff[k].root[RW-2:0], rge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) begin
            div_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i <= RW; i++) begin
            rt_ff[i].valid <= 1'b0;
         end
      end else begin
         div_ff <= div_in;
         rt_ff  <= rt_in;
      end
   end

   // saturation and sign of the results
   assign root_x = DSW'(rt_ff[RW].root);
   assign ceil_v = {1'b0, rt_ff[RW].pquo} + (PQW+1)'(rt_ff[RW].prem_nz);

   always_comb begin
      out_dist_in = (root_x > DSW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                      : root_x[OW-1:0];
      if (!rt_ff[RW].rn_neg) begin
         out_proj_in = (rt_ff[RW].povf || rt_ff[RW].pquo[PQW-1]) ? psd_pkg::PROJ_MAX
                                                                : rt_ff[RW].pquo;
      end else if (rt_ff[RW].povf || (ceil_v > (PQW+1)'(psd_pkg::PROJ_MIN))) begin
         out_proj_in = psd_pkg::PROJ_MIN;
      end else begin
         out_proj_in = '0 - ceil_v[PQW-1:0];
      end
      if (rt_ff[RW].degenerate) begin
         out_dist_in = '0;
         out_proj_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= rt_ff[RW].valid;
      end
   end

   always_ff @(posedge clock) begin
      out_dist_ff  <= out_dist_in;
      out_proj_ff  <= out_proj_in;
      out_degen_ff <= rt_ff[RW].degenerate;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_distance   = out_dist_ff;
   assign rsp_projection = signed'(out_proj_ff);
   assign rsp_degenerate = out_degen_ff;

endmodule

>>> hw/rtl/point_segment_distance.sv
// Point to segment distance: top level joining front, queue and back parts.
// Depends on psd_pkg, psd_front, psd_queue, psd_back.
//
// Use:
//   Drive the six coordinates on req_* and raise start. The item is taken at
//   a rising edge where start is high and busy is low. Each item gives one
//   result: rsp_valid is high for exactly one cycle with rsp_distance,
//   rsp_projection (signed Q16.16, saturated) and rsp_degenerate.
//   The receiver cannot stall; results must be taken when presented.
// Timing:
//   The accepting edge loads the first of 109 register stages: 5 front
//   stages, one queue slot, a squaring stage, a divide setup stage, Q_W = 66
//   divide stages (one quotient bit each), a root setup stage, ROOT_W = 33
//   square-root stages (one root bit each) and an output register.
//   Throughput is one item per cycle while busy is low; every stage is a
//   plain pipeline step.
// Stalls:
//   The back part drains the queue every cycle, so busy (queue full) stays
//   low in operation; if it ever rises, the front holds its contents.
// Reset:
//   Synchronous, active high. Clears all valid bits and the queue; items in
//   flight are dropped. No memory needs clearing.
module point_segment_distance (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_point_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_point_lat,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_start_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_start_lat,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_end_lon,
   input  logic signed [psd_pkg::COORD_W-1:0]   req_end_lat,
   output logic                                 rsp_valid,
   output logic [psd_pkg::OUT_W-1:0]            rsp_distance,
   output logic signed [psd_pkg::OUT_W-1:0]     rsp_projection,
   output logic                                 rsp_degenerate
);

   logic                  push, full, pop;
   psd_pkg::psd_item_type wr_item, rd_item;

   // front stalls only when the queue is full
   assign busy = full;

   psd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .en            (!full),
      .req_point_lon (req_point_lon),
      .req_point_lat (req_point_lat),
      .req_start_lon (req_start_lon),
      .req_start_lat (req_start_lat),
      .req_end_lon   (req_end_lon),
      .req_end_lat   (req_end_lat),
      .push          (push),
      .item          (wr_item)
   );

   psd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (wr_item),
      .full    (full),
      .pop     (pop),
      .rd_item (rd_item)
   );

   // back: divide and root pipelines, one item per cycle
   psd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop            (pop),
      .rd_item        (rd_item),
      .rsp_valid      (rsp_valid),
      .rsp_distance   (rsp_distance),
      .rsp_projection (rsp_projection),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

>>> sim/tb.sv
// Self-checking bench for point_segment_distance: directed and random segment queries.
// Depends on psd_pkg and the point_segment_distance RTL; the expected values
// come from an exact wide-integer calculation inside this file.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY    = 3 * psd_pkg::COORD_W + 12;
   localparam int STALL_MAX  = 4000;    // cycles with no item taken and no result out
   localparam int N_RANDOM   = 1130;
   localparam int ROOT_BITS  = 34;      // width of the exact bit-by-bit searches
   localparam longint C_LIM  = 1800000000;

   typedef logic signed [psd_pkg::COORD_W-1:0] coord_type;

   typedef struct {
      coord_type px, py, sx, sy, ex, ey;
   } query_type;

   typedef struct {
      logic [psd_pkg::OUT_W-1:0] distance;
      logic [psd_pkg::OUT_W-1:0] projection;
      logic                      degenerate;
   } answer_type;

   logic clock, reset, start, busy;
   coord_type req_point_lon, req_point_lat, req_start_lon, req_start_lat;
   coord_type req_end_lon, req_end_lat;
   logic                             rsp_valid, rsp_degenerate;
   logic [psd_pkg::OUT_W-1:0]        rsp_distance;
   logic signed [psd_pkg::OUT_W-1:0] rsp_projection;

   query_type  pending_q[$];     // items waiting to be driven
   answer_type answer_q[$];      // answers of accepted items, oldest first
   int      n_fail   = 0;
   int      n_taken  = 0;
   int      idle_pct = 37;    // sender idle rate of the current phase
   int      quiet_cycles = 0;

   point_segment_distance dut (
      .clock, .reset, .start, .busy,
      .req_point_lon, .req_point_lat, .req_start_lon, .req_start_lat,
      .req_end_lon, .req_end_lat,
      .rsp_valid, .rsp_distance, .rsp_projection, .rsp_degenerate
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Largest x below 2^ROOT_BITS with x*x*a <= b (squared) or x*a <= b.
   function automatic logic [255:0] bit_search(logic [255:0] a, logic [255:0] b,
                                               bit squared);
      logic [255:0] x, t, p;
      x = '0;
      for (int i = ROOT_BITS - 1; i >= 0; i--) begin
         t = x | (256'd1 << i);
         p = squared ? t * t * a : t * a;
         if (p <= b) x = t;
      end
      return x;
   endfunction

   // Exact distance, Q16.16 projection and degenerate flag of one query.
   function automatic answer_type segment_answer(query_type q);
      answer_type a;
      logic signed [127:0] dx, dy, ux, uy, vx, vy, rn, rd, cr, d1, d2;
      logic [255:0] rn_mag, cr_mag, m, dist_v, num, quo;
      bit rn_neg;
      dx = 128'(q.ex) - 128'(q.sx);
      dy = 128'(q.ey) - 128'(q.sy);
      ux = 128'(q.px) - 128'(q.sx);
      uy = 128'(q.py) - 128'(q.sy);
      vx = 128'(q.px) - 128'(q.ex);
      vy = 128'(q.py) - 128'(q.ey);
      a.degenerate = 1'b0;
      if (dx == 0 && dy == 0) begin
         a.distance   = '0;
         a.projection = '0;
         a.degenerate = 1'b1;
         return a;
      end
      rn = ux * dx + uy * dy;
      rd = dx * dx + dy * dy;
      cr = ux * dy - uy * dx;
      rn_neg = rn < 0;
      rn_mag = 256'(rn_neg ? -rn : rn);
      cr_mag = 256'(cr < 0 ? -cr : cr);
      if (!rn_neg && rn <= rd) begin
         // foot of the perpendicular on the segment
         dist_v = bit_search(256'(rd), cr_mag * cr_mag, 1'b1);
      end else begin
         d1 = ux * ux + uy * uy;
         d2 = vx * vx + vy * vy;
         m = 256'((d1 < d2) ? d1 : d2);
         dist_v = bit_search(256'd1, m, 1'b1);
      end
      a.distance = (dist_v > 256'hFFFF_FFFF) ? psd_pkg::DIST_MAX
                                             : dist_v[psd_pkg::OUT_W-1:0];
      num = rn_mag << psd_pkg::FRAC_BITS;
      quo = bit_search(256'(rd), num, 1'b0);
      if (!rn_neg) begin
         a.projection = (quo > 256'h7FFF_FFFF) ? psd_pkg::PROJ_MAX
                                               : quo[psd_pkg::OUT_W-1:0];
      end else begin
         // floor toward minus infinity: bump the magnitude when inexact
         if (quo * 256'(rd) != num) quo = quo + 1;
         if (quo > 256'h8000_0000) quo = 256'h8000_0000;
         a.projection = -quo[psd_pkg::OUT_W-1:0];
      end
      return a;
   endfunction

   function automatic coord_type any_coord();
      return coord_type'(longint'($urandom_range(3600000000, 0)) - C_LIM);
   endfunction

   function automatic coord_type near(coord_type c, int span);
      longint v;
      v = longint'(c) + longint'($urandom_range(2 * span, 0)) - span;
      if (v > C_LIM) v = C_LIM;
      if (v < -C_LIM) v = -C_LIM;
      return coord_type'(v);
   endfunction

   function automatic query_type make_query(coord_type px, coord_type py, coord_type sx,
                                            coord_type sy, coord_type ex, coord_type ey);
      query_type q;
      q.px = px; q.py = py; q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
      return q;
   endfunction

   // Random query: mostly genuine segments at assorted scales, a few
   // degenerate ones and some with raw 32-bit patterns.
   function automatic query_type random_query();
      query_type q;
      int kind, span;
      kind = $urandom_range(99);
      span = (kind < 30) ? 1000 : (kind < 55) ? 1 << $urandom_range(30, 4) : 0;
      q.sx = any_coord();
      q.sy = any_coord();
      if (span != 0) begin
         q.ex = near(q.sx, span);
         q.ey = near(q.sy, span);
         q.px = near(q.sx, 2 * span);
         q.py = near(q.sy, 2 * span);
      end else begin
         q.ex = any_coord();
         q.ey = any_coord();
         q.px = any_coord();
         q.py = any_coord();
      end
      if (kind >= 90 && kind < 95) begin
         q.ex = q.sx;
         q.ey = q.sy;
      end else if (kind >= 95) begin
         // full bit patterns, out of nominal range on purpose
         q.px = coord_type'($urandom);
         q.py = coord_type'($urandom);
         q.sx = coord_type'($urandom);
         q.ey = coord_type'($urandom);
      end
      return q;
   endfunction

   // Driver: offers the head of pending_q, with random gaps per phase.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         bit offer;
         query_type q;
         offer = start && busy;            // held item stays up
         if (start && !busy) begin
            q = make_query(req_point_lon, req_point_lat, req_start_lon,
                           req_start_lat, req_end_lon, req_end_lat);
            answer_q.push_back(segment_answer(q));
            n_taken++;
            idle_pct = (n_taken < 383) ? 37 : (n_taken < 766) ? 60 : 0;
         end
         if (!offer && pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            q = pending_q.pop_front();
            req_point_lon <= q.px;
            req_point_lat <= q.py;
            req_start_lon <= q.sx;
            req_start_lat <= q.sy;
            req_end_lon   <= q.ex;
            req_end_lat   <= q.ey;
            offer = 1'b1;
         end
         start <= offer;
      end
   end

   // Monitor: every strobed result is checked against the oldest answer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answer_type exp_a;
         if (answer_q.size() == 0) begin
            $error("result with no item outstanding: distance %0d", rsp_distance);
            n_fail++;
         end else begin
            exp_a = answer_q.pop_front();
            if (rsp_distance !== exp_a.distance) begin
               $error("distance: expected %0d, got %0d", exp_a.distance, rsp_distance);
               n_fail++;
            end
            if (rsp_projection !== exp_a.projection) begin
               $error("projection: expected %h, got %h", exp_a.projection,
                      rsp_projection);
               n_fail++;
            end
            if (rsp_degenerate !== exp_a.degenerate) begin
               $error("degenerate: expected %b, got %b", exp_a.degenerate,
                      rsp_degenerate);
               n_fail++;
            end
         end
      end
   end

   // Watchdog: a stretch with neither an item taken nor a result out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      coord_type hi, lo;
      hi = coord_type'(C_LIM);
      lo = coord_type'(-C_LIM);
      reset = 1'b1;
      start = 1'b0;
      {req_point_lon, req_point_lat, req_start_lon, req_start_lat} = '0;
      {req_end_lon, req_end_lat} = '0;

      // degenerate segments, including the extremes
      pending_q.push_back(make_query(0, 0, 0, 0, 0, 0));
      pending_q.push_back(make_query(hi, lo, lo, hi, lo, hi));
      pending_q.push_back(make_query(5, 7, 100, -3, 100, -3));
      // foot of the perpendicular inside, at each end, and beyond each end
      pending_q.push_back(make_query(3, 4, 0, 0, 10, 0));
      pending_q.push_back(make_query(0, 9, 0, 0, 10, 0));
      pending_q.push_back(make_query(10, -9, 0, 0, 10, 0));
      pending_q.push_back(make_query(-7, 3, 0, 0, 10, 0));
      pending_q.push_back(make_query(25, -3, 0, 0, 10, 0));
      pending_q.push_back(make_query(5, 5, 0, 0, 10, 0));      // endpoints equidistant
      pending_q.push_back(make_query(1, 1, 0, 0, 7, 3));       // positive fraction below one
      pending_q.push_back(make_query(-1, 2, 0, 0, 7, 3));      // projection rounds down
      // far apart: the first saturates the distance; the second has the point on an end
      pending_q.push_back(make_query(lo, lo, hi, hi, hi, coord_type'(1700000000)));
      pending_q.push_back(make_query(hi, lo, lo, hi, hi, lo));
      pending_q.push_back(make_query(lo, lo, hi, hi, lo, hi));
      // very short segment: projection saturates both ways
      pending_q.push_back(make_query(hi, 0, 0, 0, 1, 0));
      pending_q.push_back(make_query(lo, 0, 0, 0, 1, 0));
      pending_q.push_back(make_query(0, hi, 0, 0, 0, -1));
      // long diagonal across the whole range
      pending_q.push_back(make_query(0, 0, lo, lo, hi, hi));
      pending_q.push_back(make_query(hi, lo, lo, lo, hi, hi));
      // raw 32-bit extremes, on every field in the first query
      pending_q.push_back(make_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
      pending_q.push_back(make_query(-1, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -1, 0));
      for (int i = 0; i < N_RANDOM; i++) pending_q.push_back(random_query());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (pending_q.size() == 0 && !start);
      wait (answer_q.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (n_fail == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_queue.sv
hw/rtl/psd_back.sv
hw/rtl/point_segment_distance.sv
sim/tb.sv
